### rtl/ttf_pkg.sv
package ttf_pkg;

   localparam int NORMAL_WIDTH = 48;
   localparam int FRAME_WIDTH  = 16;

endpackage

### rtl/triangle_tangent_frame_unit.sv
// Channel  Direction  Handshake              Word
// req      in         req_push / req_full    one vertex (position, texture coordinate)
// rsp      out        rsp_pop / rsp_empty    one corner: normal, tangent, bitangent, coordinate
// csr      in         csr_valid / csr_ready  use_generated_uv
//
// Vertices enter at one per cycle while the two-entry triangle queue has room.
// The back end works on a triangle with the shared multiplier, the square root
// loop and the quotient loop. The normalization shift is at most 11 at default
// widths, and a vector that is zero or has a zero determinant skips the
// normalization and gets a zero frame.
// Reset is synchronous and clears the corner count, the quad phase and the queues.
// The result stage holds one triangle, so the back end stalls only when it is full.
module triangle_tangent_frame_unit #(
   parameter int POS_WIDTH   = 24,
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_data,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [POS_WIDTH-1:0]   req_pos_x,
   input  logic signed [POS_WIDTH-1:0]   req_pos_y,
   input  logic signed [POS_WIDTH-1:0]   req_pos_z,
   input  logic signed [COORD_WIDTH-1:0] req_tex_u,
   input  logic signed [COORD_WIDTH-1:0] req_tex_v,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [ttf_pkg::NORMAL_WIDTH-1:0] rsp_normal_x,
   output logic signed [ttf_pkg::NORMAL_WIDTH-1:0] rsp_normal_y,
   output logic signed [ttf_pkg::NORMAL_WIDTH-1:0] rsp_normal_z,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  rsp_tangent_x,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  rsp_tangent_y,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  rsp_tangent_z,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  rsp_bitangent_x,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  rsp_bitangent_y,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  rsp_bitangent_z,
   output logic signed [COORD_WIDTH-1:0] rsp_out_u,
   output logic signed [COORD_WIDTH-1:0] rsp_out_v,
   output logic                          rsp_last_of_triangle
);
   import ttf_pkg::*;

   localparam int JW = 9 * POS_WIDTH + 6 * COORD_WIDTH;

   logic          job_push, job_full, job_pop, job_empty;
   logic [JW-1:0] job_in, job_out;

   assign csr_ready = 1'b1;

   ttf_front #(.PW(POS_WIDTH), .CW(COORD_WIDTH), .JW(JW)) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_data (csr_data),
      .req_push (req_push),
      .req_full (req_full),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .tex_u    (req_tex_u),
      .tex_v    (req_tex_v),
      .job_push (job_push),
      .job_full (job_full),
      .job_data (job_in)
   );

   ttf_queue #(.W(JW)) u_queue (
      .clock(clock),
      .reset(reset),
      .push (job_push),
      .full (job_full),
      .din  (job_in),
      .pop  (job_pop),
      .empty(job_empty),
      .dout (job_out)
   );

   ttf_back #(.PW(POS_WIDTH), .CW(COORD_WIDTH), .JW(JW)) u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty       (job_empty),
      .job_pop         (job_pop),
      .job_data        (job_out),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .normal_x        (rsp_normal_x),
      .normal_y        (rsp_normal_y),
      .normal_z        (rsp_normal_z),
      .tangent_x       (rsp_tangent_x),
      .tangent_y       (rsp_tangent_y),
      .tangent_z       (rsp_tangent_z),
      .bitangent_x     (rsp_bitangent_x),
      .bitangent_y     (rsp_bitangent_y),
      .bitangent_z     (rsp_bitangent_z),
      .out_u           (rsp_out_u),
      .out_v           (rsp_out_v),
      .last_of_triangle(rsp_last_of_triangle)
   );

endmodule

### rtl/ttf_front.sv
module ttf_front #(
   parameter int PW = 24,
   parameter int CW = 16,
   parameter int JW = 9 * 24 + 6 * 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_data,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic signed [PW-1:0] pos_x,
   input  logic signed [PW-1:0] pos_y,
   input  logic signed [PW-1:0] pos_z,
   input  logic signed [CW-1:0] tex_u,
   input  logic signed [CW-1:0] tex_v,
   output logic                 job_push,
   input  logic                 job_full,
   output logic [JW-1:0]        job_data
);
   import ttf_pkg::*;

   localparam logic signed [CW-1:0] UV_ONE = {{3{1'b0}}, 1'b1, {(CW - 4){1'b0}}};

   logic [1:0] corner_ff, corner_in;
   logic [1:0] quad_ff, quad_in;
   logic       use_gen_ff, use_gen_in;
   logic signed [PW-1:0] hp_ff [6];
   logic signed [CW-1:0] hc_ff [4];
   logic                 accept;
   logic signed [CW-1:0] u_sel, v_sel;

   assign req_full = (corner_ff == 2'd2) && job_full;
   assign accept   = req_push && !req_full;
   assign job_push = accept && (corner_ff == 2'd2);

   always_comb begin
      u_sel = tex_u;
      v_sel = tex_v;
      if (use_gen_ff) begin
         u_sel = (quad_ff == 2'd1 || quad_ff == 2'd2) ? UV_ONE : '0;
         v_sel = quad_ff[1] ? UV_ONE : '0;
      end
   end

   assign job_data = {v_sel, u_sel, hc_ff[3], hc_ff[2], hc_ff[1], hc_ff[0],
                      pos_z, pos_y, pos_x,
                      hp_ff[5], hp_ff[4], hp_ff[3], hp_ff[2], hp_ff[1], hp_ff[0]};

   always_comb begin
      corner_in  = corner_ff;
      quad_in    = quad_ff;
      use_gen_in = csr_valid ? csr_data : use_gen_ff;
      if (accept) begin
         quad_in   = quad_ff + 2'd1;
         corner_in = (corner_ff == 2'd2) ? 2'd0 : corner_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff  <= '0;
         quad_ff    <= '0;
         use_gen_ff <= 1'b0;
      end else begin
         corner_ff  <= corner_in;
         quad_ff    <= quad_in;
         use_gen_ff <= use_gen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && corner_ff != 2'd2) begin
         if (corner_ff[0] == 1'b0) begin
            hp_ff[0] <= pos_x;
            hp_ff[1] <= pos_y;
            hp_ff[2] <= pos_z;
            hc_ff[0] <= u_sel;
            hc_ff[1] <= v_sel;
         end else begin
            hp_ff[3] <= pos_x;
            hp_ff[4] <= pos_y;
            hp_ff[5] <= pos_z;
            hc_ff[2] <= u_sel;
            hc_ff[3] <= v_sel;
         end
      end
   end

endmodule

### rtl/ttf_queue.sv
module ttf_queue #(
   parameter int W = 312
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [W-1:0] din,
   input  logic         pop,
   output logic         empty,
   output logic [W-1:0] dout
);
   import ttf_pkg::*;

   logic [W-1:0] mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign dout    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### rtl/ttf_back.sv
module ttf_back #(
   parameter int PW = 24,
   parameter int CW = 16,
   parameter int JW = 9 * 24 + 6 * 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_empty,
   output logic          job_pop,
   input  logic [JW-1:0] job_data,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic signed [ttf_pkg::NORMAL_WIDTH-1:0] normal_x,
   output logic signed [ttf_pkg::NORMAL_WIDTH-1:0] normal_y,
   output logic signed [ttf_pkg::NORMAL_WIDTH-1:0] normal_z,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  tangent_x,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  tangent_y,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  tangent_z,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  bitangent_x,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  bitangent_y,
   output logic signed [ttf_pkg::FRAME_WIDTH-1:0]  bitangent_z,
   output logic signed [CW-1:0] out_u,
   output logic signed [CW-1:0] out_v,
   output logic          last_of_triangle
);
   import ttf_pkg::*;

   localparam int EW   = PW + 1;
   localparam int DW   = CW + 1;
   localparam int MW0  = (EW > DW) ? EW : DW;
   localparam int MW   = (MW0 > 31) ? MW0 : 31;
   localparam int PRW  = 2 * MW;
   localparam int TW   = DW + EW + 1;
   localparam int MGW  = (TW > 31) ? TW : 31;
   localparam int SW   = 64;
   localparam int RW   = 31;
   localparam int QW   = FRAME_WIDTH - 1;
   localparam int DVW  = 47;
   localparam int NW   = NORMAL_WIDTH;
   localparam int FW   = FRAME_WIDTH;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_COMB  = 4'd2;
   localparam logic [3:0] ST_NINIT = 4'd3;
   localparam logic [3:0] ST_SHIFT = 4'd4;
   localparam logic [3:0] ST_SQ    = 4'd5;
   localparam logic [3:0] ST_SQRT  = 4'd6;
   localparam logic [3:0] ST_DLOAD = 4'd7;
   localparam logic [3:0] ST_DIV   = 4'd8;
   localparam logic [3:0] ST_WAIT  = 4'd9;

   localparam logic [4:0] LAST_PROD = 5'd19;

   localparam logic signed [PRW:0] SAT_HI = {{(PRW + 2 - NW){1'b0}}, {(NW - 1){1'b1}}};
   localparam logic signed [PRW:0] SAT_LO = {{(PRW + 2 - NW){1'b1}}, {(NW - 1){1'b0}}};

   logic [3:0] state_ff, state_in;
   logic [4:0] mul_idx_ff, mul_idx_in;
   logic       vsel_ff, vsel_in;
   logic [1:0] sq_idx_ff, sq_idx_in;
   logic [4:0] k_ff, k_in;
   logic [1:0] div_comp_ff, div_comp_in;
   logic [3:0] div_bit_ff, div_bit_in;
   logic       ob_busy_ff, ob_busy_in;
   logic [1:0] ob_corner_ff, ob_corner_in;

   logic signed [PW-1:0] pj [9];
   logic signed [CW-1:0] cj [6];

   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] e2_ff [3];
   logic signed [DW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [CW-1:0] cu_ff [3];
   logic signed [CW-1:0] cv_ff [3];
   logic signed [PRW-1:0] prod_ff [20];
   logic signed [NW-1:0] nrm_ff [3];
   logic                 det_zero_ff, det_neg_ff;
   logic signed [TW-1:0] tv_ff [3];
   logic signed [TW-1:0] bv_ff [3];
   logic [MGW-1:0]       mag_ff [3];
   logic [MGW-1:0]       top_ff;
   logic                 neg_ff [3];
   logic [SW-1:0]        sum_ff, rem_ff, res_ff;
   logic [DVW-1:0]       drem_ff;
   logic [QW-1:0]        q_ff;
   logic signed [FW-1:0] fr_ff [2][3];

   logic signed [NW-1:0] ob_nrm_ff [3];
   logic signed [FW-1:0] ob_fr_ff [2][3];
   logic signed [CW-1:0] ob_u_ff [3];
   logic signed [CW-1:0] ob_v_ff [3];

   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [PRW-1:0] mul_p;
   logic signed [PRW:0]   dn [3];
   logic signed [PRW:0]   ddet;
   logic signed [PRW:0]   dt [3];
   logic signed [PRW:0]   db [3];
   logic signed [NW-1:0]  nsat [3];
   logic signed [TW-1:0]  vec [3];
   logic [MGW-1:0]        av [3];
   logic [MGW-1:0]        vtop;
   logic                  vzero;
   logic [29:0]           sq_mag;
   logic [SW-1:0]         sum_nx, sq_bit, sq_trial;
   logic [DVW-1:0]        dsh;
   logic                  d_ge;
   logic [QW-1:0]         q_nx;
   logic signed [FW-1:0]  q_signed;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         pj[k] = job_data[k * PW +: PW];
      end
      for (int k = 0; k < 6; k++) begin
         cj[k] = job_data[9 * PW + k * CW +: CW];
      end
   end

   // Shared multiplier.
   assign sq_mag = mag_ff[sq_idx_ff][29:0];
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SQ) begin
         mul_a = $signed({{(MW - 30){1'b0}}, sq_mag});
         mul_b = $signed({{(MW - 30){1'b0}}, sq_mag});
      end else begin
         case (mul_idx_ff)
            5'd0: begin mul_a = MW'(e1_ff[1]); mul_b = MW'(e2_ff[2]); end
            5'd1: begin mul_a = MW'(e1_ff[2]); mul_b = MW'(e2_ff[1]); end
            5'd2: begin mul_a = MW'(e1_ff[2]); mul_b = MW'(e2_ff[0]); end
            5'd3: begin mul_a = MW'(e1_ff[0]); mul_b = MW'(e2_ff[2]); end
            5'd4: begin mul_a = MW'(e1_ff[0]); mul_b = MW'(e2_ff[1]); end
            5'd5: begin mul_a = MW'(e1_ff[1]); mul_b = MW'(e2_ff[0]); end
            5'd6: begin mul_a = MW'(du1_ff); mul_b = MW'(dv2_ff); end
            5'd7: begin mul_a = MW'(du2_ff); mul_b = MW'(dv1_ff); end
            5'd8: begin mul_a = MW'(dv2_ff); mul_b = MW'(e1_ff[0]); end
            5'd9: begin mul_a = MW'(dv1_ff); mul_b = MW'(e2_ff[0]); end
            5'd10: begin mul_a = MW'(dv2_ff); mul_b = MW'(e1_ff[1]); end
            5'd11: begin mul_a = MW'(dv1_ff); mul_b = MW'(e2_ff[1]); end
            5'd12: begin mul_a = MW'(dv2_ff); mul_b = MW'(e1_ff[2]); end
            5'd13: begin mul_a = MW'(dv1_ff); mul_b = MW'(e2_ff[2]); end
            5'd14: begin mul_a = MW'(du1_ff); mul_b = MW'(e2_ff[0]); end
            5'd15: begin mul_a = MW'(du2_ff); mul_b = MW'(e1_ff[0]); end
            5'd16: begin mul_a = MW'(du1_ff); mul_b = MW'(e2_ff[1]); end
            5'd17: begin mul_a = MW'(du2_ff); mul_b = MW'(e1_ff[1]); end
            5'd18: begin mul_a = MW'(du1_ff); mul_b = MW'(e2_ff[2]); end
            5'd19: begin mul_a = MW'(du2_ff); mul_b = MW'(e1_ff[2]); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
   end
   assign mul_p = mul_a * mul_b;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         dn[j] = (PRW + 1)'(prod_ff[2 * j]) - (PRW + 1)'(prod_ff[2 * j + 1]);
         dt[j] = (PRW + 1)'(prod_ff[8 + 2 * j]) - (PRW + 1)'(prod_ff[9 + 2 * j]);
         db[j] = (PRW + 1)'(prod_ff[14 + 2 * j]) - (PRW + 1)'(prod_ff[15 + 2 * j]);
         if (dn[j] > SAT_HI) begin
            nsat[j] = SAT_HI[NW-1:0];
         end else if (dn[j] < SAT_LO) begin
            nsat[j] = SAT_LO[NW-1:0];
         end else begin
            nsat[j] = dn[j][NW-1:0];
         end
      end
      ddet = (PRW + 1)'(prod_ff[6]) - (PRW + 1)'(prod_ff[7]);
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         vec[j] = vsel_ff ? bv_ff[j] : tv_ff[j];
         av[j]  = MGW'(vec[j][TW-1] ? TW'(-vec[j]) : TW'(vec[j]));
      end
      vtop = av[0];
      if (av[1] > vtop) begin
         vtop = av[1];
      end
      if (av[2] > vtop) begin
         vtop = av[2];
      end
      vzero = det_zero_ff || (vtop == '0);
   end

   assign sum_nx   = ((sq_idx_ff == 2'd0) ? '0 : sum_ff) + SW'(mul_p);
   assign sq_bit   = SW'(1) << {k_ff, 1'b0};
   assign sq_trial = res_ff + sq_bit;

   assign dsh      = DVW'({res_ff[RW-1:0], 1'b0}) << div_bit_ff;
   assign d_ge     = (drem_ff >= dsh);
   assign q_nx     = q_ff | (QW'(d_ge) << div_bit_ff);
   assign q_signed = neg_ff[div_comp_ff] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});

   assign job_pop = (state_ff == ST_IDLE) && !job_empty;

   always_comb begin
      state_in     = state_ff;
      mul_idx_in   = mul_idx_ff;
      vsel_in      = vsel_ff;
      sq_idx_in    = sq_idx_ff;
      k_in         = k_ff;
      div_comp_in  = div_comp_ff;
      div_bit_in   = div_bit_ff;
      ob_busy_in   = ob_busy_ff;
      ob_corner_in = ob_corner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               state_in   = ST_MUL;
               mul_idx_in = '0;
            end
         end
         ST_MUL: begin
            if (mul_idx_ff == LAST_PROD) begin
               state_in = ST_COMB;
            end else begin
               mul_idx_in = mul_idx_ff + 5'd1;
            end
         end
         ST_COMB: begin
            state_in = ST_NINIT;
            vsel_in  = 1'b0;
         end
         ST_NINIT: begin
            if (vzero) begin
               if (vsel_ff) begin
                  state_in = ST_WAIT;
               end else begin
                  vsel_in = 1'b1;
               end
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (top_ff[MGW-1:30] == '0) begin
               state_in  = ST_SQ;
               sq_idx_in = '0;
            end
         end
         ST_SQ: begin
            if (sq_idx_ff == 2'd2) begin
               state_in = ST_SQRT;
               k_in     = 5'd31;
            end else begin
               sq_idx_in = sq_idx_ff + 2'd1;
            end
         end
         ST_SQRT: begin
            if (k_ff == '0) begin
               state_in    = ST_DLOAD;
               div_comp_in = '0;
            end else begin
               k_in = k_ff - 5'd1;
            end
         end
         ST_DLOAD: begin
            state_in   = ST_DIV;
            div_bit_in = 4'(QW - 1);
         end
         ST_DIV: begin
            if (div_bit_ff == '0) begin
               if (div_comp_ff == 2'd2) begin
                  if (vsel_ff) begin
                     state_in = ST_WAIT;
                  end else begin
                     vsel_in  = 1'b1;
                     state_in = ST_NINIT;
                  end
               end else begin
                  div_comp_in = div_comp_ff + 2'd1;
                  state_in    = ST_DLOAD;
               end
            end else begin
               div_bit_in = div_bit_ff - 4'd1;
            end
         end
         ST_WAIT: begin
            if (!ob_busy_ff) begin
               state_in     = ST_IDLE;
               ob_busy_in   = 1'b1;
               ob_corner_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (rsp_pop && ob_busy_ff) begin
         if (ob_corner_ff == 2'd2) begin
            ob_busy_in   = 1'b0;
            ob_corner_in = '0;
         end else begin
            ob_corner_in = ob_corner_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mul_idx_ff   <= '0;
         vsel_ff      <= 1'b0;
         sq_idx_ff    <= '0;
         k_ff         <= '0;
         div_comp_ff  <= '0;
         div_bit_ff   <= '0;
         ob_busy_ff   <= 1'b0;
         ob_corner_ff <= '0;
      end else begin
         state_ff     <= state_in;
         mul_idx_ff   <= mul_idx_in;
         vsel_ff      <= vsel_in;
         sq_idx_ff    <= sq_idx_in;
         k_ff         <= k_in;
         div_comp_ff  <= div_comp_in;
         div_bit_ff   <= div_bit_in;
         ob_busy_ff   <= ob_busy_in;
         ob_corner_ff <= ob_corner_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               for (int j = 0; j < 3; j++) begin
                  e1_ff[j] <= EW'(pj[3 + j]) - EW'(pj[j]);
                  e2_ff[j] <= EW'(pj[6 + j]) - EW'(pj[j]);
                  cu_ff[j] <= cj[2 * j];
                  cv_ff[j] <= cj[2 * j + 1];
               end
               du1_ff <= DW'(cj[2]) - DW'(cj[0]);
               dv1_ff <= DW'(cj[3]) - DW'(cj[1]);
               du2_ff <= DW'(cj[4]) - DW'(cj[0]);
               dv2_ff <= DW'(cj[5]) - DW'(cj[1]);
            end
         end
         ST_MUL: begin
            prod_ff[mul_idx_ff] <= mul_p;
         end
         ST_COMB: begin
            for (int j = 0; j < 3; j++) begin
               nrm_ff[j] <= nsat[j];
               tv_ff[j]  <= dt[j][TW-1:0];
               bv_ff[j]  <= db[j][TW-1:0];
            end
            det_zero_ff <= (ddet == '0);
            det_neg_ff  <= ddet[PRW];
         end
         ST_NINIT: begin
            top_ff <= vtop;
            for (int j = 0; j < 3; j++) begin
               mag_ff[j] <= av[j];
               neg_ff[j] <= vec[j][TW-1] ^ det_neg_ff;
               if (vzero) begin
                  fr_ff[vsel_ff][j] <= '0;
               end
            end
         end
         ST_SHIFT: begin
            if (top_ff[MGW-1:30] != '0) begin
               top_ff <= top_ff >> 1;
               for (int j = 0; j < 3; j++) begin
                  mag_ff[j] <= mag_ff[j] >> 1;
               end
            end
         end
         ST_SQ: begin
            sum_ff <= sum_nx;
            if (sq_idx_ff == 2'd2) begin
               rem_ff <= sum_nx;
               res_ff <= '0;
            end
         end
         ST_SQRT: begin
            if (rem_ff >= sq_trial) begin
               rem_ff <= rem_ff - sq_trial;
               res_ff <= (res_ff >> 1) + sq_bit;
            end else begin
               res_ff <= res_ff >> 1;
            end
         end
         ST_DLOAD: begin
            drem_ff <= DVW'({mag_ff[div_comp_ff][29:0], {QW{1'b0}}})
                       + DVW'(res_ff[RW-1:0]);
            q_ff    <= '0;
         end
         ST_DIV: begin
            if (d_ge) begin
               drem_ff <= drem_ff - dsh;
            end
            q_ff <= q_nx;
            if (div_bit_ff == '0) begin
               fr_ff[vsel_ff][div_comp_ff] <= q_signed;
            end
         end
         ST_WAIT: begin
            if (!ob_busy_ff) begin
               ob_nrm_ff <= nrm_ff;
               ob_fr_ff  <= fr_ff;
               ob_u_ff   <= cu_ff;
               ob_v_ff   <= cv_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_empty        = !ob_busy_ff;
   assign normal_x         = ob_nrm_ff[0];
   assign normal_y         = ob_nrm_ff[1];
   assign normal_z         = ob_nrm_ff[2];
   assign tangent_x        = ob_fr_ff[0][0];
   assign tangent_y        = ob_fr_ff[0][1];
   assign tangent_z        = ob_fr_ff[0][2];
   assign bitangent_x      = ob_fr_ff[1][0];
   assign bitangent_y      = ob_fr_ff[1][1];
   assign bitangent_z      = ob_fr_ff[1][2];
   assign out_u            = ob_u_ff[ob_corner_ff];
   assign out_v            = ob_v_ff[ob_corner_ff];
   assign last_of_triangle = (ob_corner_ff == 2'd2);

`ifndef ASSERT_OFF
   a_pop_starts_mul: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (state_ff == ST_MUL && mul_idx_ff == '0))
      else $error("triangle pop did not start the product sequence");

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && k_ff == '0) |=> (res_ff[SW-1:RW] == '0))
      else $error("square root result exceeds its width");

   a_zero_det_frame: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && det_zero_ff) |->
      (fr_ff[0][0] == '0 && fr_ff[0][1] == '0 && fr_ff[0][2] == '0 &&
       fr_ff[1][0] == '0 && fr_ff[1][1] == '0 && fr_ff[1][2] == '0))
      else $error("frame not cleared for a degenerate texture mapping");

   a_last_frees_stage: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && ob_busy_ff && ob_corner_ff == 2'd2) |=> !ob_busy_ff)
      else $error("result stage still busy after its last word");
`endif

endmodule

### tb/sv/tb_triangle_tangent_frame_unit.sv
module tb_triangle_tangent_frame_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W    = 24;
   localparam int COORD_W  = 16;
   localparam int NRM_W    = ttf_pkg::NORMAL_WIDTH;
   localparam int FRM_W    = ttf_pkg::FRAME_WIDTH;
   localparam int SETTLE   = 300;
   localparam int MAX_CYCLES = 400000;

   typedef struct packed {
      logic signed [NRM_W-1:0] nx, ny, nz;
      logic signed [FRM_W-1:0] tx, ty, tz, bx, by, bz;
      logic signed [COORD_W-1:0] u, v;
      logic last;
   } corner_type;

   class frame_scoreboard_type;
      corner_type pending[$];
      bit gen_uv;
      longint held_pos[6];
      longint held_uv[4];
      int corners;
      int phase;
      int errors;
      int checked;
      int triangles;

      function void reset_state();
         gen_uv = 0;
         corners = 0;
         phase = 0;
      endfunction

      function longint unsigned magn(longint a);
         return (a < 0) ? -a : a;
      endfunction

      function longint cross_term(longint a, longint b, longint c, longint d);
         longint unsigned m1, m2, lim, rm;
         bit n1, n2, neg;
         m1 = magn(a) * magn(b);
         m2 = magn(c) * magn(d);
         n1 = ((a < 0) != (b < 0)) && m1 != 0;
         n2 = ((c < 0) != (d < 0)) && m2 != 0;
         lim = 64'd1 << (NRM_W - 1);
         if (n1 != n2) begin
            neg = n1;
            rm = (m1 >= lim || m2 >= lim) ? lim : m1 + m2;
         end else if (m1 >= m2) begin
            rm = m1 - m2;
            neg = n1;
         end else begin
            rm = m2 - m1;
            neg = !n1;
         end
         if (neg) return (rm >= lim) ? -longint'(lim) : -longint'(rm);
         return (rm >= lim) ? longint'(lim - 1) : longint'(rm);
      endfunction

      function longint unsigned root_floor(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function void unit_dir(input longint x[3], input bit flip,
                             output logic signed [FRM_W-1:0] r[3]);
         longint unsigned m[3], top, sum, len;
         longint q;
         int s;
         top = 0;
         sum = 0;
         s = 0;
         for (int i = 0; i < 3; i++) begin
            m[i] = magn(x[i]);
            if (m[i] > top) top = m[i];
         end
         if (top == 0) begin
            for (int i = 0; i < 3; i++) r[i] = '0;
            return;
         end
         while ((top >> s) >= (64'd1 << 30)) s++;
         for (int i = 0; i < 3; i++) begin
            m[i] >>= s;
            sum += m[i] * m[i];
         end
         len = root_floor(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 15) + len) / (len * 2);
            r[i] = FRM_W'(((x[i] < 0) != flip) ? -q : q);
         end
      endfunction

      function void note_vertex(logic signed [POS_W-1:0] px, py, pz,
                                logic signed [COORD_W-1:0] tu, tv_in);
         longint p[9], c[6], e1[3], e2[3], tvec[3], bvec[3], nrm[3];
         longint u, v, du1, dv1, du2, dv2, det;
         logic signed [FRM_W-1:0] tn[3], bn[3];
         corner_type w;
         u = tu;
         v = tv_in;
         if (gen_uv) begin
            u = (phase == 1 || phase == 2) ? (64'd1 << (COORD_W - 4)) : 0;
            v = (phase >= 2) ? (64'd1 << (COORD_W - 4)) : 0;
         end
         phase = (phase + 1) % 4;
         if (corners < 2) begin
            held_pos[corners*3] = px;
            held_pos[corners*3+1] = py;
            held_pos[corners*3+2] = pz;
            held_uv[corners*2] = u;
            held_uv[corners*2+1] = v;
            corners++;
            return;
         end
         corners = 0;
         triangles++;
         for (int j = 0; j < 6; j++) p[j] = held_pos[j];
         p[6] = px; p[7] = py; p[8] = pz;
         for (int j = 0; j < 4; j++) c[j] = held_uv[j];
         c[4] = u; c[5] = v;
         for (int j = 0; j < 3; j++) begin
            e1[j] = p[3+j] - p[j];
            e2[j] = p[6+j] - p[j];
         end
         nrm[0] = cross_term(e1[1], e2[2], e1[2], e2[1]);
         nrm[1] = cross_term(e1[2], e2[0], e1[0], e2[2]);
         nrm[2] = cross_term(e1[0], e2[1], e1[1], e2[0]);
         du1 = c[2] - c[0]; dv1 = c[3] - c[1];
         du2 = c[4] - c[0]; dv2 = c[5] - c[1];
         det = du1 * dv2 - du2 * dv1;
         for (int j = 0; j < 3; j++) begin
            tvec[j] = dv2 * e1[j] - dv1 * e2[j];
            bvec[j] = du1 * e2[j] - du2 * e1[j];
         end
         if (det == 0) begin
            for (int j = 0; j < 3; j++) begin
               tn[j] = '0;
               bn[j] = '0;
            end
         end else begin
            unit_dir(tvec, det < 0, tn);
            unit_dir(bvec, det < 0, bn);
         end
         for (int k = 0; k < 3; k++) begin
            w.nx = NRM_W'(nrm[0]); w.ny = NRM_W'(nrm[1]); w.nz = NRM_W'(nrm[2]);
            w.tx = tn[0]; w.ty = tn[1]; w.tz = tn[2];
            w.bx = bn[0]; w.by = bn[1]; w.bz = bn[2];
            w.u = COORD_W'(c[k*2]);
            w.v = COORD_W'(c[k*2+1]);
            w.last = (k == 2);
            pending.insert(pending.size(), w);
         end
      endfunction

      function void report(string name, longint e, longint a);
         $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
         errors++;
      endfunction

      function void check_corner(corner_type a);
         corner_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word, actual %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.nx !== e.nx) report("normal_x", e.nx, a.nx);
         if (a.ny !== e.ny) report("normal_y", e.ny, a.ny);
         if (a.nz !== e.nz) report("normal_z", e.nz, a.nz);
         if (a.tx !== e.tx) report("tangent_x", e.tx, a.tx);
         if (a.ty !== e.ty) report("tangent_y", e.ty, a.ty);
         if (a.tz !== e.tz) report("tangent_z", e.tz, a.tz);
         if (a.bx !== e.bx) report("bitangent_x", e.bx, a.bx);
         if (a.by !== e.by) report("bitangent_y", e.by, a.by);
         if (a.bz !== e.bz) report("bitangent_z", e.bz, a.bz);
         if (a.u !== e.u) report("out_u", e.u, a.u);
         if (a.v !== e.v) report("out_v", e.v, a.v);
         if (a.last !== e.last) report("last_of_triangle", e.last, a.last);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_data = 0;
   logic req_push = 0;
   logic req_full;
   logic signed [POS_W-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [COORD_W-1:0] req_tex_u = '0, req_tex_v = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   wire corner_type got;

   frame_scoreboard_type sb;
   int cycles = 0;
   int pop_wait = 0;
   bit no_gaps = 0;
   logic signed [POS_W-1:0] last_x = '0, last_y = '0, last_z = '0;

   triangle_tangent_frame_unit dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_push(req_push), .req_full(req_full),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_tex_u(req_tex_u), .req_tex_v(req_tex_v),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_normal_x(got.nx), .rsp_normal_y(got.ny), .rsp_normal_z(got.nz),
      .rsp_tangent_x(got.tx), .rsp_tangent_y(got.ty), .rsp_tangent_z(got.tz),
      .rsp_bitangent_x(got.bx), .rsp_bitangent_y(got.by), .rsp_bitangent_z(got.bz),
      .rsp_out_u(got.u), .rsp_out_v(got.v), .rsp_last_of_triangle(got.last)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYCLES) begin
         $display("triangle_tangent_frame_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            sb.check_corner(got);
            pop_wait = no_gaps ? 0 : $urandom_range(0, 4);
            if (pop_wait > 0) rsp_pop <= 0;
         end else if (!rsp_pop) begin
            if (pop_wait == 0) rsp_pop <= 1;
            else pop_wait--;
         end
      end
   end

   task automatic send_vertex(logic signed [POS_W-1:0] x, y, z,
                              logic signed [COORD_W-1:0] u, v);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      req_tex_u <= u;
      req_tex_v <= v;
      do @(negedge clock); while (req_full);
      @(posedge clock);
      sb.note_vertex(x, y, z, u, v);
      last_x = x;
      last_y = y;
      last_z = z;
   endtask

   task automatic write_mode(bit m);
      csr_valid <= 1;
      csr_data <= m;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 0;
      sb.gen_uv = m;
   endtask

   task automatic drain();
      req_push <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_bits(int w);
      int n;
      logic [31:0] r;
      n = $urandom_range(1, w);
      r = $urandom & ((32'd1 << n) - 1);
      if (n < w && $urandom_range(0, 1)) r = -r;
      return r;
   endfunction

   task automatic random_vertices(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_vertex(last_x, last_y, last_z, COORD_W'(rand_bits(COORD_W)),
                        COORD_W'(rand_bits(COORD_W)));
         else
            send_vertex(POS_W'(rand_bits(POS_W)), POS_W'(rand_bits(POS_W)),
                        POS_W'(rand_bits(POS_W)),
                        COORD_W'(rand_bits(COORD_W)), COORD_W'(rand_bits(COORD_W)));
      end
   endtask

   localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

   initial begin
      sb = new();
      sb.reset_state();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_mode(0);
      // Positive and negative normal saturation with extreme texture coordinates.
      send_vertex(PMIN, PMIN, PMIN, CMIN, CMIN);
      send_vertex(PMAX, PMIN, PMIN, CMAX, CMIN);
      send_vertex(PMIN, PMAX, PMIN, CMIN, CMAX);
      send_vertex(PMIN, PMIN, PMIN, CMAX, CMAX);
      send_vertex(PMIN, PMAX, PMIN, CMIN, CMAX);
      send_vertex(PMAX, PMIN, PMIN, CMAX, CMIN);
      // Zero determinant.
      send_vertex(100, 200, 300, 4096, 4096);
      send_vertex(5000, -200, 7, 4096, 4096);
      send_vertex(-9000, 1234, 77, 4096, 4096);
      // Degenerate triangle: zero vectors with a nonzero determinant.
      send_vertex(-1, -1, -1, 0, 0);
      send_vertex(-1, -1, -1, 4096, 0);
      send_vertex(-1, -1, -1, 0, 4096);
      // Small ordinary triangle with mirrored mapping.
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(4096, 0, 0, 0, 4096);
      send_vertex(0, 4096, 0, 4096, 0);
      // Leave one corner held across the mode change.
      send_vertex(123456, -654321, 42, -1, 1);
      drain();
      write_mode(1);
      send_vertex(-300000, 2000, 900000, CMAX, CMIN);
      send_vertex(77, PMAX, -5, CMIN, CMAX);
      send_vertex(1, 2, 3, 0, 0);
      send_vertex(PMAX, PMAX, PMAX, 0, 0);
      random_vertices(40);
      drain();
      write_mode(0);
      no_gaps = 1;
      random_vertices(25);
      no_gaps = 0;
      random_vertices(30);
      drain();
      write_mode(1);
      random_vertices(30);
      drain();
      write_mode(0);
      random_vertices(29);
      drain();
      $display("Covered %0d triangles, %0d corner words checked, both texture modes,",
               sb.triangles, sb.checked);
      $display("normal saturation, zero determinant and degenerate edges.");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("triangle_tangent_frame_unit: match");
      end else begin
         $display("triangle_tangent_frame_unit: mismatch");
      end
      $finish;
   end
endmodule
